>>> hw/rtl/clc_pkg.sv
// Shared types, character codes and helpers for the comment line classifier.
package clc_pkg;

    // Width of each running total; results carry the low 32 bits.
    localparam int COUNT_BITS = 32;
    localparam int TOTAL_BITS = 32;

    // Character codes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;

    // Prefix match bits
    localparam int HIT_C    = 0;
    localparam int HIT_HTML = 1;
    localparam int HIT_LINE = 2;

    typedef enum logic [1:0] {
        LK_BLANK   = 2'd0,
        LK_COMMENT = 2'd1,
        LK_CODE    = 2'd2
    } t_line_kind;

    typedef enum logic [1:0] {
        BM_NONE = 2'd0,
        BM_C    = 2'd1,
        BM_HTML = 2'd2
    } t_block_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_item;

    typedef struct packed {
        t_line_kind            line_kind;
        logic [TOTAL_BITS-1:0] blank_total;
        logic [TOTAL_BITS-1:0] comment_total;
        logic [TOTAL_BITS-1:0] code_total;
        logic                  end_of_text;
    } t_out_item;

    // Line end report from the scanner to the tally
    typedef struct packed {
        logic       valid;
        t_line_kind kind;
        logic       fin;
    } t_line_end;

    typedef struct packed {
        logic [TOTAL_BITS-1:0] blank;
        logic [TOTAL_BITS-1:0] comment;
        logic [TOTAL_BITS-1:0] code;
    } t_totals;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

    // Expected byte of the HTML opener at a given prefix position
    function automatic logic [7:0] html_open_char(input logic [1:0] p);
        logic [7:0] c;
        case (p)
            2'd0: c = CH_LT;
            2'd1: c = CH_BANG;
            default: c = CH_DASH;
        endcase
        return c;
    endfunction

    // Low 32 bits of a total, zero-extended where the total is narrower
    function automatic logic [TOTAL_BITS-1:0] to_total(input logic [COUNT_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[TOTAL_BITS-1:0];
    endfunction

endpackage

>>> hw/rtl/comment_line_classifier_unit.sv
// Top level of the comment line classifier: input register, scanner, tally, result register.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item): one byte of text per
//   item, with a flag on the final byte. Output channel (o_out_valid /
//   i_out_stall / o_out_item): one item for each line that ends, carrying its
//   class (blank, comment, code), the three running totals and an
//   end-of-text flag. Bytes inside a line produce no output item.
//   Throughput: one byte per cycle, sustained, while the output is not stalled.
//   Path: a line-ending byte is taken into the input register, then scanned
//   and tallied into the result register in one short pass of logic.
//   Stall: when the result register holds an item and i_out_stall is high,
//   the whole pipe holds and o_in_stall goes high in the same cycle; a held
//   result never changes.
//   Reset (i_rst_n low at a clock edge): both pipe stages empty, block
//   comment mode and line state cleared, totals zero. The totals then run
//   on across texts until the next reset, saturating at their maximum.
module comment_line_classifier_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  clc_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output clc_pkg::t_out_item o_out_item
);
    import clc_pkg::*;

    logic      advance;
    logic      scan_en;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_line_end line_end;
    t_totals   totals;

    // Pipe moves unless a finished result is held by the receiver
    assign advance    = !(r_out_valid && i_out_stall);
    assign o_in_stall = !advance;
    assign scan_en    = advance && r_in_valid;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (advance) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    clc_line_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (scan_en),
        .i_item     (r_in_item),
        .o_line_end (line_end)
    );

    clc_tally u_tally (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (scan_en),
        .i_line_end (line_end),
        .o_totals   (totals)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid && line_end.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_en && line_end.valid) begin
            r_out_item.line_kind     <= line_end.kind;
            r_out_item.blank_total   <= totals.blank;
            r_out_item.comment_total <= totals.comment;
            r_out_item.code_total    <= totals.code;
            r_out_item.end_of_text   <= line_end.fin;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> hw/rtl/clc_line_scan.sv
// Per-byte line scanner: prefix match, end markers, block mode and line class.
module clc_line_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  clc_pkg::t_in_item   i_item,
    output clc_pkg::t_line_end  o_line_end
);
    import clc_pkg::*;

    t_block_mode r_block_mode, n_block_mode;
    logic        r_seen, n_seen;
    logic [2:0]  r_pos, n_pos;
    logic [2:0]  r_hits, n_hits;
    logic        r_star, n_star;
    logic [1:0]  r_dash, n_dash;
    logic        r_c_end, n_c_end;
    logic        r_c_tail, n_c_tail;
    logic        r_h_end, n_h_end;
    logic        r_h_tail, n_h_tail;

    // Scan the byte into the line state, then close the line if it ends here
    always_comb begin
        logic [7:0] c;
        logic       ws;
        logic       ends;
        t_line_kind kind;

        c    = i_item.ch;
        ws   = is_ws(c);
        ends = (c == CH_LF) || i_item.last;
        kind = LK_CODE;

        n_block_mode = r_block_mode;
        n_seen   = r_seen;
        n_pos    = r_pos;
        n_hits   = r_hits;
        n_star   = r_star;
        n_dash   = r_dash;
        n_c_end  = r_c_end;
        n_c_tail = r_c_tail;
        n_h_end  = r_h_end;
        n_h_tail = r_h_tail;

        if (c != CH_LF) begin
            // first text byte restarts prefix matching
            if (!ws && !r_seen) begin
                n_seen = 1'b1;
                n_hits = 3'b111;
                n_pos  = 3'd0;
            end
            if (n_seen && (n_pos < 3'd4)) begin
                if ((n_pos < 3'd2) && (c != (n_pos[0] ? CH_STAR : CH_SLASH)))
                    n_hits[HIT_C] = 1'b0;
                if (c != html_open_char(n_pos[1:0]))
                    n_hits[HIT_HTML] = 1'b0;
                if ((n_pos < 3'd2) && (c != CH_SLASH))
                    n_hits[HIT_LINE] = 1'b0;
                n_pos = n_pos + 3'd1;
            end

            // C end marker and text after it
            if ((c == CH_SLASH) && r_star && !r_c_end)
                n_c_end = 1'b1;
            else if (r_c_end && !ws)
                n_c_tail = 1'b1;

            // HTML end marker and text after it
            if ((c == CH_GT) && (r_dash == 2'd2) && !r_h_end)
                n_h_end = 1'b1;
            else if (r_h_end && !ws)
                n_h_tail = 1'b1;

            n_star = (c == CH_STAR);
            if (c == CH_DASH)
                n_dash = (r_dash == 2'd2) ? 2'd2 : r_dash + 2'd1;
            else
                n_dash = 2'd0;
        end

        if (ends) begin
            // classify from the scanned state
            if (!n_seen) begin
                kind = LK_BLANK;
            end else begin
                case (r_block_mode)
                    BM_C: begin
                        kind = (n_c_end && n_c_tail) ? LK_CODE : LK_COMMENT;
                        if (n_c_end)
                            n_block_mode = BM_NONE;
                    end
                    BM_HTML: begin
                        kind = (n_h_end && n_h_tail) ? LK_CODE : LK_COMMENT;
                        if (n_h_end)
                            n_block_mode = BM_NONE;
                    end
                    default: begin
                        n_block_mode = BM_NONE;
                        if (n_hits[HIT_C] && (n_pos >= 3'd2)) begin
                            if (!n_c_end) begin
                                kind = LK_COMMENT;
                                n_block_mode = BM_C;
                            end else begin
                                kind = n_c_tail ? LK_CODE : LK_COMMENT;
                            end
                        end else if (n_hits[HIT_HTML] && (n_pos >= 3'd4)) begin
                            if (!n_h_end) begin
                                kind = LK_COMMENT;
                                n_block_mode = BM_HTML;
                            end else begin
                                kind = n_h_tail ? LK_CODE : LK_COMMENT;
                            end
                        end else if (n_hits[HIT_LINE] && (n_pos >= 3'd2)) begin
                            kind = LK_COMMENT;
                        end else begin
                            kind = LK_CODE;
                        end
                    end
                endcase
            end
            if (i_item.last)
                n_block_mode = BM_NONE;

            // fresh line
            n_seen   = 1'b0;
            n_pos    = 3'd0;
            n_hits   = 3'd0;
            n_star   = 1'b0;
            n_dash   = 2'd0;
            n_c_end  = 1'b0;
            n_c_tail = 1'b0;
            n_h_end  = 1'b0;
            n_h_tail = 1'b0;
        end

        o_line_end.valid = ends;
        o_line_end.kind  = kind;
        o_line_end.fin   = i_item.last;
    end

    // Line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_mode <= BM_NONE;
            r_seen   <= 1'b0;
            r_pos    <= 3'd0;
            r_hits   <= 3'd0;
            r_star   <= 1'b0;
            r_dash   <= 2'd0;
            r_c_end  <= 1'b0;
            r_c_tail <= 1'b0;
            r_h_end  <= 1'b0;
            r_h_tail <= 1'b0;
        end else if (i_en) begin
            r_block_mode <= n_block_mode;
            r_seen   <= n_seen;
            r_pos    <= n_pos;
            r_hits   <= n_hits;
            r_star   <= n_star;
            r_dash   <= n_dash;
            r_c_end  <= n_c_end;
            r_c_tail <= n_c_tail;
            r_h_end  <= n_h_end;
            r_h_tail <= n_h_tail;
        end
    end

endmodule

>>> hw/rtl/clc_tally.sv
// Three saturating line totals, bumped by the class of each ended line.
module clc_tally (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  clc_pkg::t_line_end  i_line_end,
    output clc_pkg::t_totals    o_totals
);
    import clc_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [COUNT_BITS-1:0] r_blank, n_blank;
    logic [COUNT_BITS-1:0] r_comment, n_comment;
    logic [COUNT_BITS-1:0] r_code, n_code;

    // Next totals, including the line that ends now
    always_comb begin
        n_blank   = r_blank;
        n_comment = r_comment;
        n_code    = r_code;
        if (i_line_end.valid) begin
            case (i_line_end.kind)
                LK_BLANK:   n_blank   = (r_blank == COUNT_MAX) ? r_blank : r_blank + 1'b1;
                LK_COMMENT: n_comment = (r_comment == COUNT_MAX) ? r_comment
                                                                 : r_comment + 1'b1;
                default:    n_code    = (r_code == COUNT_MAX) ? r_code : r_code + 1'b1;
            endcase
        end
        o_totals.blank   = to_total(n_blank);
        o_totals.comment = to_total(n_comment);
        o_totals.code    = to_total(n_code);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank   <= '0;
            r_comment <= '0;
            r_code    <= '0;
        end else if (i_en) begin
            r_blank   <= n_blank;
            r_comment <= n_comment;
            r_code    <= n_code;
        end
    end

endmodule
